### sv/lpmf_pkg.sv
// shared types and codes for the length-prefixed message fifo
package lpmf_pkg;

   localparam int SIZE_W = 11;
   localparam int BYTE_W = 8;

   localparam logic [1:0] ACT_PUSH_HDR  = 2'd0;
   localparam logic [1:0] ACT_PUSH_DATA = 2'd1;
   localparam logic [1:0] ACT_POP       = 2'd2;

   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_NO_SPACE = 2'd1;
   localparam logic [1:0] STS_EMPTY    = 2'd2;
   localparam logic [1:0] STS_SEQ_ERR  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HDR_WR,
      ST_POP_LEN,
      ST_POP_DATA,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic              last_byte;
      logic [SIZE_W-1:0] out_size;
      logic [BYTE_W-1:0] out_byte;
      logic [1:0]        status;
   } result_type;

endpackage

### sv/lpmf_ram.sv
// generic single-write single-read ram with registered read data
module lpmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/lpmf_core.sv
// sequencer for pushes and pops, pointer state and store access
module lpmf_core #(
   parameter int CAPACITY = 1024,
   parameter int RESERVE  = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                item_valid,
   output logic                                item_ready,
   input  logic [1:0]                          item_action,
   input  logic [lpmf_pkg::SIZE_W-1:0]         item_size,
   input  logic [lpmf_pkg::BYTE_W-1:0]         item_byte,
   output logic                                res_valid,
   output lpmf_pkg::result_type                res_data,
   input  logic                                out_free,
   output logic                                mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0]         mem_wr_addr,
   output logic [lpmf_pkg::BYTE_W-1:0]         mem_wr_data,
   output logic                                mem_rd_en,
   output logic [$clog2(CAPACITY)-1:0]         mem_rd_addr,
   input  logic [lpmf_pkg::BYTE_W-1:0]         mem_rd_data
);
   import lpmf_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int PW = AW + 1;
   localparam int SW = (PW > SIZE_W + 1) ? PW : SIZE_W + 1;
   localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      logic [PW-1:0] n;
      n = {1'b0, p} + PW'(1);
      return (n >= CAP_P) ? '0 : n[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] align_commit(input logic [AW-1:0] p);
      logic [PW-1:0] n;
      n = {1'b0, p} + PW'(3);
      n[1:0] = 2'b00;
      return (n >= CAP_P) ? '0 : n[AW-1:0];
   endfunction

   state_type         state_ff, state_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     tail_ff, tail_in;
   logic [AW-1:0]     wcur_ff, wcur_in;
   logic [AW-1:0]     rcur_ff, rcur_in;
   logic [SIZE_W-1:0] push_left_ff, push_left_in;
   logic              push_open_ff, push_open_in;
   logic [AW-1:0]     pop_left_ff, pop_left_in;
   logic [SIZE_W-1:0] pop_total_ff, pop_total_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [23:0]       len_ff, len_in;
   result_type        res_ff, res_in;

   logic [PW-1:0]     fill;
   logic [PW-1:0]     free_space;
   logic [SW-1:0]     need;
   logic [31:0]       len_full;
   logic              post;
   result_type        post_res;

   always_comb begin
      if (tail_ff >= head_ff) begin
         fill = PW'(tail_ff) - PW'(head_ff);
      end else begin
         fill = PW'(tail_ff) + CAP_P - PW'(head_ff);
      end
      free_space = CAP_P - fill;
      need       = SW'(item_size) + SW'(RESERVE);
      len_full   = {mem_rd_data, len_ff};
   end

   assign item_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      wcur_in      = wcur_ff;
      rcur_in      = rcur_ff;
      push_left_in = push_left_ff;
      push_open_in = push_open_ff;
      pop_left_in  = pop_left_ff;
      pop_total_in = pop_total_ff;
      size_in      = size_ff;
      len_in       = len_ff;
      res_in       = res_ff;
      post         = 1'b0;
      post_res     = '0;
      res_valid    = 1'b0;
      res_data     = res_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wcur_ff;
      mem_wr_data  = item_byte;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = rcur_ff;

      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               case (item_action)
                  ACT_PUSH_HDR: begin
                     if (push_open_ff) begin
                        post            = 1'b1;
                        post_res.status = STS_SEQ_ERR;
                     end else if (item_size == '0) begin
                        post = 1'b1;
                     end else if (SW'(free_space) < need) begin
                        post            = 1'b1;
                        post_res.status = STS_NO_SPACE;
                     end else begin
                        size_in  = item_size;
                        wcur_in  = tail_ff;
                        cnt_in   = 2'd0;
                        state_in = ST_HDR_WR;
                     end
                  end
                  ACT_PUSH_DATA: begin
                     post = 1'b1;
                     if (!push_open_ff) begin
                        post_res.status = STS_SEQ_ERR;
                     end else begin
                        mem_wr_en    = 1'b1;
                        wcur_in      = wrap_inc(wcur_ff);
                        push_left_in = push_left_ff - SIZE_W'(1);
                        if (push_left_ff == SIZE_W'(1)) begin
                           tail_in      = align_commit(wrap_inc(wcur_ff));
                           push_open_in = 1'b0;
                        end
                     end
                  end
                  ACT_POP: begin
                     if (pop_left_ff != '0) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = rcur_ff;
                        rcur_in     = wrap_inc(rcur_ff);
                        state_in    = ST_POP_DATA;
                     end else if (fill <= PW'(4)) begin
                        post            = 1'b1;
                        post_res.status = STS_EMPTY;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = head_ff;
                        rcur_in     = wrap_inc(head_ff);
                        cnt_in      = 2'd0;
                        state_in    = ST_POP_LEN;
                     end
                  end
                  default: begin
                     post = 1'b1;
                  end
               endcase
            end
         end
         ST_HDR_WR: begin
            mem_wr_en = 1'b1;
            case (cnt_ff)
               2'd0:    mem_wr_data = size_ff[7:0];
               2'd1:    mem_wr_data = BYTE_W'(size_ff[SIZE_W-1:8]);
               default: mem_wr_data = '0;
            endcase
            wcur_in = wrap_inc(wcur_ff);
            cnt_in  = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               push_left_in = size_ff;
               push_open_in = 1'b1;
               post         = 1'b1;
            end
         end
         ST_POP_LEN: begin
            case (cnt_ff)
               2'd0:    len_in[7:0]   = mem_rd_data;
               2'd1:    len_in[15:8]  = mem_rd_data;
               2'd2:    len_in[23:16] = mem_rd_data;
               default: len_in        = len_ff;
            endcase
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff != 2'd3) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rcur_ff;
               rcur_in     = wrap_inc(rcur_ff);
            end else if (len_full == '0 || len_full > 32'(fill)) begin
               post            = 1'b1;
               post_res.status = STS_EMPTY;
            end else begin
               pop_left_in  = len_full[AW-1:0];
               pop_total_in = len_full[SIZE_W-1:0];
               mem_rd_en    = 1'b1;
               mem_rd_addr  = rcur_ff;
               rcur_in      = wrap_inc(rcur_ff);
               state_in     = ST_POP_DATA;
            end
         end
         ST_POP_DATA: begin
            post              = 1'b1;
            post_res.out_byte = mem_rd_data;
            post_res.out_size = pop_total_ff;
            pop_left_in       = pop_left_ff - AW'(1);
            if (pop_left_ff == AW'(1)) begin
               post_res.last_byte = 1'b1;
               head_in            = align_commit(rcur_ff);
            end
         end
         ST_WAIT: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (post) begin
         if (out_free) begin
            res_valid = 1'b1;
            res_data  = post_res;
            state_in  = ST_IDLE;
         end else begin
            res_in   = post_res;
            state_in = ST_WAIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         wcur_ff      <= '0;
         rcur_ff      <= '0;
         push_left_ff <= '0;
         push_open_ff <= 1'b0;
         pop_left_ff  <= '0;
         pop_total_ff <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         wcur_ff      <= wcur_in;
         rcur_ff      <= rcur_in;
         push_left_ff <= push_left_in;
         push_open_ff <= push_open_in;
         pop_left_ff  <= pop_left_in;
         pop_total_ff <= pop_total_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff <= size_in;
      len_ff  <= len_in;
      res_ff  <= res_in;
   end

endmodule

### sv/length_prefixed_message_fifo_top.sv
// push data, rejects, errors and other one-beat cases post from idle; a header push first
// writes four length bytes; a byte pop reads the store, then posts; the first pop of a message
// does 4 length reads and one data read through the single registered read port of the byte
// store; push data runs one beat per cycle while the output register is free; other beats
// hold input until posted; a result waits in the output register while the next beat is taken;
// synchronous reset clears pointers and control; the byte store itself is not cleared
module length_prefixed_message_fifo_top #(
   parameter int CAPACITY = 1024,
   parameter int RESERVE  = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // msg_size [10:0], data_byte [18:11], zero fill
   input  logic [1:0]  req_tuser,   // action [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_byte [7:0], out_size [18:8], zero fill
   output logic [1:0]  rsp_tuser,   // status [1:0]
   output logic        rsp_tlast
);
   import lpmf_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   logic              res_valid;
   result_type        res_data;
   logic              out_free;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [BYTE_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [BYTE_W-1:0] mem_rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff, rsp_data_in;

   lpmf_core #(
      .CAPACITY (CAPACITY),
      .RESERVE  (RESERVE)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (req_tvalid),
      .item_ready  (req_tready),
      .item_action (req_tuser),
      .item_size   (req_tdata[10:0]),
      .item_byte   (req_tdata[18:11]),
      .res_valid   (res_valid),
      .res_data    (res_data),
      .out_free    (out_free),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   lpmf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff.out_size, rsp_data_ff.out_byte};
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tlast  = rsp_data_ff.last_byte;

endmodule

### tb/length_prefixed_message_fifo_checker.sv
// response checker for the length-prefixed message fifo: predicts each response and compares
module length_prefixed_message_fifo_checker #(
   parameter int CAPACITY = 1024,
   parameter int RESERVE  = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // msg_size [10:0], data_byte [18:11], zero fill
   input  logic [1:0]  req_tuser,   // action [1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // out_byte [7:0], out_size [18:8], zero fill
   input  logic [1:0]  rsp_tuser,   // status [1:0]
   input  logic        rsp_tlast,
   output int          error_count,
   output int          outstanding
);
   import lpmf_pkg::*;

   localparam int PTR_W = $clog2(CAPACITY);

   logic [BYTE_W-1:0] byte_store [CAPACITY];
   logic [PTR_W-1:0]  head_ptr;
   logic [PTR_W-1:0]  tail_ptr;
   logic [PTR_W-1:0]  write_ptr;
   logic [PTR_W-1:0]  read_ptr;
   logic [SIZE_W-1:0] push_remaining;
   logic [SIZE_W-1:0] pop_remaining;
   logic [SIZE_W-1:0] pop_length;
   logic              push_active;
   result_type        expected_responses [$];
   int                mismatches = 0;
   int                waiting = 0;

   assign error_count = mismatches;
   assign outstanding = waiting;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (int'(p) + 1 >= CAPACITY) ? '0 : PTR_W'(int'(p) + 1);
   endfunction

   // message boundaries sit on 4-byte steps, wrapping to zero at capacity
   function automatic logic [PTR_W-1:0] align_ptr(input logic [PTR_W-1:0] p);
      int q;
      q = (int'(p) + 3) & ~3;
      return (q >= CAPACITY) ? '0 : PTR_W'(q);
   endfunction

   function automatic int fill_level();
      return (int'(tail_ptr) + CAPACITY - int'(head_ptr)) % CAPACITY;
   endfunction

   task automatic predict_response(input logic [1:0] action, input logic [SIZE_W-1:0] size,
                                   input logic [BYTE_W-1:0] data_byte, output result_type res);
      int               fill;
      int               length;
      logic [PTR_W-1:0] p;
      logic             ready;
      res = '0;
      case (action)
         ACT_PUSH_HDR: begin
            if (push_active) begin
               res.status = STS_SEQ_ERR;
            end else if (size != 0) begin
               if (CAPACITY - fill_level() < int'(size) + RESERVE) begin
                  res.status = STS_NO_SPACE;
               end else begin
                  p = tail_ptr;
                  for (int i = 0; i < 4; i++) begin
                     byte_store[p] = BYTE_W'(size >> (8 * i));
                     p = next_ptr(p);
                  end
                  write_ptr = p;
                  push_remaining = size;
                  push_active = 1'b1;
               end
            end
         end
         ACT_PUSH_DATA: begin
            if (!push_active) begin
               res.status = STS_SEQ_ERR;
            end else begin
               byte_store[write_ptr] = data_byte;
               write_ptr = next_ptr(write_ptr);
               push_remaining = push_remaining - 1'b1;
               if (push_remaining == 0) begin
                  tail_ptr = align_ptr(write_ptr);
                  push_active = 1'b0;
               end
            end
         end
         ACT_POP: begin
            ready = 1'b1;
            if (pop_remaining == 0) begin
               fill = fill_level();
               if (fill <= 4) begin
                  ready = 1'b0;
               end else begin
                  p = head_ptr;
                  length = 0;
                  for (int i = 0; i < 4; i++) begin
                     length = length | (int'(byte_store[p]) << (8 * i));
                     p = next_ptr(p);
                  end
                  if (length == 0 || length > fill) begin
                     ready = 1'b0;
                  end else begin
                     read_ptr = p;
                     pop_remaining = SIZE_W'(length);
                     pop_length = SIZE_W'(length);
                  end
               end
            end
            if (!ready) begin
               res.status = STS_EMPTY;
            end else begin
               res.out_byte = byte_store[read_ptr];
               res.out_size = pop_length;
               read_ptr = next_ptr(read_ptr);
               pop_remaining = pop_remaining - 1'b1;
               if (pop_remaining == 0) begin
                  res.last_byte = 1'b1;
                  head_ptr = align_ptr(read_ptr);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      result_type predicted;
      result_type want;
      if (reset) begin
         head_ptr = '0;
         tail_ptr = '0;
         write_ptr = '0;
         read_ptr = '0;
         push_remaining = '0;
         pop_remaining = '0;
         pop_length = '0;
         push_active = 1'b0;
         expected_responses.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            predict_response(req_tuser, req_tdata[10:0], req_tdata[18:11], predicted);
            expected_responses.push_back(predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_responses.size() == 0) begin
               $error("response beat with no request waiting");
               mismatches++;
            end else begin
               want = expected_responses.pop_front();
               check_field("status", want.status, rsp_tuser);
               check_field("out_byte", want.out_byte, rsp_tdata[7:0]);
               check_field("out_size", want.out_size, rsp_tdata[18:8]);
               check_field("last_byte", want.last_byte, rsp_tlast);
            end
         end
      end
      waiting = expected_responses.size();
   end

endmodule

### tb/length_prefixed_message_fifo_top_tb.sv
// testbench top: drives message traffic into the fifo and reports the verdict
module length_prefixed_message_fifo_top_tb;
   import lpmf_pkg::*;

   localparam int CAPACITY     = 1024;
   localparam int RESERVE      = 4;
   localparam int TOTAL_BEATS  = 1400;
   localparam logic [1:0] ACT_NONE = 2'd3;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // msg_size [10:0], data_byte [18:11], zero fill
   logic [1:0]  req_tuser = '0;   // action [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // out_byte [7:0], out_size [18:8], zero fill
   logic [1:0]  rsp_tuser;        // status [1:0]
   logic        rsp_tlast;

   int error_count;
   int outstanding;
   bit sender_calm = 1'b0;
   bit receiver_calm = 1'b0;
   int stall_left = 0;
   int beat_count = 0;
   int queued_sizes [$];
   int queued_bytes = 0;
   int front_popped = 0;

   length_prefixed_message_fifo_top #(.CAPACITY(CAPACITY), .RESERVE(RESERVE)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   length_prefixed_message_fifo_checker #(.CAPACITY(CAPACITY), .RESERVE(RESERVE)) response_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int align4(input int n);
      return (n + 3) & ~3;
   endfunction

   function automatic int pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return 0;
      if (r < 78) return $urandom_range(1, 12);
      if (r < 96) return $urandom_range(13, 120);
      return $urandom_range(121, 600);
   endfunction

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_left = pick_gap(receiver_calm);
      end
      rsp_tready = (stall_left == 0);
      if (stall_left > 0) begin
         stall_left--;
      end
   end

   // called and returns at a falling edge
   task automatic send_beat(input logic [1:0] action, input logic [SIZE_W-1:0] size,
                            input logic [BYTE_W-1:0] data_byte);
      int gap;
      gap = pick_gap(sender_calm);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser = action;
      req_tdata = {5'b0, data_byte, size};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      beat_count++;
   endtask

   task automatic drain_wait();
      req_tvalid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic pop_beat();
      send_beat(ACT_POP, SIZE_W'($urandom), BYTE_W'($urandom));
      if (queued_sizes.size() > 0) begin
         front_popped++;
         if (front_popped == queued_sizes[0]) begin
            queued_bytes -= align4(queued_sizes[0] + 4);
            void'(queued_sizes.pop_front());
            front_popped = 0;
         end
      end
   endtask

   // well-formed message with the odd stray beat mixed in
   task automatic push_message(input int size);
      int r;
      send_beat(ACT_PUSH_HDR, SIZE_W'(size), BYTE_W'($urandom));
      for (int n = 0; n < size; n++) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            send_beat(ACT_PUSH_HDR, SIZE_W'($urandom), BYTE_W'($urandom));
         end else if (r < 7) begin
            send_beat(ACT_NONE, SIZE_W'($urandom), BYTE_W'($urandom));
         end else if (r < 12) begin
            pop_beat();
         end
         send_beat(ACT_PUSH_DATA, SIZE_W'($urandom), BYTE_W'($urandom));
      end
      if (size > 0) begin
         queued_sizes.push_back(size);
         queued_bytes += align4(size + 4);
      end
   endtask

   initial begin
      int r;
      int size;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_beat(ACT_POP, '0, '0);
      send_beat(ACT_PUSH_DATA, '0, '1);
      send_beat(ACT_NONE, '1, '1);
      send_beat(ACT_PUSH_HDR, '0, '0);
      send_beat(ACT_PUSH_HDR, 11'd2047, '0);
      send_beat(ACT_PUSH_HDR, 11'd1024, '0);
      send_beat(ACT_PUSH_HDR, 11'd1021, '0);

      // largest message writes the whole store and wraps the tail onto the head
      send_beat(ACT_PUSH_HDR, 11'd1020, '0);
      for (int n = 0; n < 1020; n++) begin
         if (n == 3) begin
            send_beat(ACT_PUSH_HDR, 11'd5, '0);
            send_beat(ACT_POP, '0, '0);
            send_beat(ACT_NONE, '0, '0);
         end
         send_beat(ACT_PUSH_DATA, SIZE_W'($urandom), BYTE_W'(n));
      end
      send_beat(ACT_POP, '0, '0);

      send_beat(ACT_PUSH_HDR, 11'd1, '0);
      send_beat(ACT_PUSH_DATA, '0, 8'hA5);
      send_beat(ACT_PUSH_HDR, 11'd2, '0);
      send_beat(ACT_PUSH_DATA, '0, 8'h00);
      send_beat(ACT_PUSH_DATA, '0, 8'hFF);
      repeat (4) send_beat(ACT_POP, '1, '1);
      drain_wait();

      while (beat_count < TOTAL_BEATS) begin
         if ($urandom_range(0, 29) == 0) sender_calm = !sender_calm;
         if ($urandom_range(0, 29) == 0) receiver_calm = !receiver_calm;
         r = $urandom_range(0, 99);
         if (r < 50) begin
            size = pick_size();
            while (queued_bytes + align4(size + 4) > CAPACITY - 4 && queued_sizes.size() > 0) begin
               pop_beat();
            end
            push_message(size);
         end else if (r < 85) begin
            repeat ($urandom_range(1, 24)) pop_beat();
         end else if (r < 91) begin
            // header too big for the free space, then orphan data
            size = $urandom_range(CAPACITY - RESERVE + 1 - queued_bytes, 2047);
            send_beat(ACT_PUSH_HDR, SIZE_W'(size), BYTE_W'($urandom));
            repeat ($urandom_range(1, 3)) send_beat(ACT_PUSH_DATA, SIZE_W'($urandom),
                                                    BYTE_W'($urandom));
         end else if (r < 97) begin
            send_beat($urandom_range(0, 1) ? ACT_PUSH_DATA : ACT_NONE, SIZE_W'($urandom),
                      BYTE_W'($urandom));
         end else begin
            drain_wait();
         end
      end

      drain_wait();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Verification failed");
      $finish;
   end

endmodule
